// ===== sv/hhu_pkg.sv =====
// ----------------------------------------------------------------------------
// hhu_pkg: shared types and constants of the Huffman header unpacker
// Field widths, field phase codes and the leaf result word.
// ----------------------------------------------------------------------------
`default_nettype none

package hhu_pkg;

	// Field widths of one input and one result word
	localparam int BYTE_W    = 8;
	localparam int SYMBOL_W  = 9;
	localparam int CODE_LEN_W = 3;
	localparam int CODE_W    = 7;
	localparam int LEFT_W    = 4;

	// Bits in the symbol field: normal leaf and final leaf
	localparam logic [LEFT_W-1:0] SYM_BITS      = 4'd8;
	localparam logic [LEFT_W-1:0] SYM_LAST_BITS = 4'd9;

	// Field phase codes
	localparam logic [1:0] PH_SYMBOL = 2'd0;
	localparam logic [1:0] PH_LENGTH = 2'd1;
	localparam logic [1:0] PH_CODE   = 2'd2;

	// One finished leaf
	typedef struct packed {
		logic [SYMBOL_W-1:0]   symbol;
		logic [CODE_LEN_W-1:0] code_length;
		logic [CODE_W-1:0]     code;
		logic                  last_entry;
	} leaf_t;

endpackage

`default_nettype wire

// ===== sv/hhu_if.sv =====
// ----------------------------------------------------------------------------
// hhu_if: valid/ready channels of the Huffman header unpacker
// Header byte channel and leaf result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface hhu_hdr_if;
	logic                         valid;
	logic                         ready;
	logic [hhu_pkg::BYTE_W-1:0]   header_byte;
	logic                         start_header;

	modport source (output valid, header_byte, start_header, input ready);
	modport sink   (input valid, header_byte, start_header, output ready);
endinterface

interface hhu_leaf_if;
	logic                             valid;
	logic                             ready;
	logic [hhu_pkg::SYMBOL_W-1:0]     symbol;
	logic [hhu_pkg::CODE_LEN_W-1:0]   code_length;
	logic [hhu_pkg::CODE_W-1:0]       code;
	logic                             last_entry;

	modport source (output valid, symbol, code_length, code, last_entry, input ready);
	modport sink   (input valid, symbol, code_length, code, last_entry, output ready);
endinterface

`default_nettype wire

// ===== sv/huffman_header_unpacker.sv =====
// A taken header word is parsed from the input register into the result register
// once that register is empty or its leaf is taken. Throughput: one word per
//   cycle while no leaf waits; the eight bits of a word are parsed in one pass,
//   at most one leaf per word. The input stalls only while a finished leaf waits.
// Reset (arst_n low): parser idle, data words ignored until a start word.
// ----------------------------------------------------------------------------
// huffman_header_unpacker: Huffman code table header parser
// Splits header bytes into symbol, code length and code fields, MSB first,
// and gives one result word per finished leaf.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_header_unpacker #(
	parameter int LENGTH_FIELD_BITS = 3
) (
	input  wire        clk,
	input  wire        arst_n,
	hhu_hdr_if.sink    hdr,
	hhu_leaf_if.source leaf
);

	localparam int LW = hhu_pkg::LEFT_W;

	// Input register
	logic                          valid_s1;
	logic [hhu_pkg::BYTE_W-1:0]    byte_s1;
	logic                          start_s1;

	// Parser state
	logic [1:0]                    phase_q;
	logic [LW-1:0]                 left_q;
	logic [7:0]                    found_q;
	logic [7:0]                    total_q;
	logic [hhu_pkg::SYMBOL_W-1:0]  sym_q;
	logic [LENGTH_FIELD_BITS-1:0]  len_q;
	logic [hhu_pkg::CODE_W-1:0]    code_q;
	logic                          done_q;

	// Result register
	logic                          valid_s2;
	hhu_pkg::leaf_t                leaf_s2;

	// Next state
	logic [1:0]                    n_phase;
	logic [LW-1:0]                 n_left;
	logic [7:0]                    n_found;
	logic [7:0]                    n_total;
	logic [hhu_pkg::SYMBOL_W-1:0]  n_sym;
	logic [LENGTH_FIELD_BITS-1:0]  n_len;
	logic [hhu_pkg::CODE_W-1:0]    n_code;
	logic                          n_done;
	logic                          res_v;
	hhu_pkg::leaf_t                res;
	logic                          advance;

	assign advance   = valid_s1 && (!valid_s2 || leaf.ready);
	assign hdr.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (hdr.ready) begin
			valid_s1 <= hdr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr.valid && hdr.ready) begin
			byte_s1  <= hdr.header_byte;
			start_s1 <= hdr.start_header;
		end
	end

	// Bit walk over one word, MSB first
	always_comb begin
		logic b;
		logic leaf_end;
		n_phase = phase_q;
		n_left  = left_q;
		n_found = found_q;
		n_total = total_q;
		n_sym   = sym_q;
		n_len   = len_q;
		n_code  = code_q;
		n_done  = done_q;
		res_v   = 1'b0;
		res     = '0;
		b        = 1'b0;
		leaf_end = 1'b0;
		if (start_s1) begin
			// Start word: leaf count, restart parsing
			n_total = byte_s1;
			n_found = 8'd0;
			n_done  = (byte_s1 == 8'd0);
			n_phase = hhu_pkg::PH_SYMBOL;
			n_left  = (byte_s1 == 8'd1) ? hhu_pkg::SYM_LAST_BITS : hhu_pkg::SYM_BITS;
			n_sym   = '0;
			n_len   = '0;
			n_code  = '0;
		end else begin
			for (int pos = 7; pos >= 0; pos--) begin
				if (!n_done) begin
					b        = byte_s1[3'(pos)];
					leaf_end = 1'b0;
					unique case (n_phase)
						hhu_pkg::PH_SYMBOL: begin
							n_sym  = {n_sym[hhu_pkg::SYMBOL_W-2:0], b};
							n_left = n_left - 1'b1;
							if (n_left == '0) begin
								n_phase = hhu_pkg::PH_LENGTH;
								n_left  = LW'(LENGTH_FIELD_BITS);
							end
						end
						hhu_pkg::PH_LENGTH: begin
							n_len  = {n_len[LENGTH_FIELD_BITS-2:0], b};
							n_left = n_left - 1'b1;
							if (n_left == '0) begin
								n_phase = hhu_pkg::PH_CODE;
								n_left  = LW'(n_len);
								leaf_end = (n_len == '0);
							end
						end
						hhu_pkg::PH_CODE: begin
							n_code = {n_code[hhu_pkg::CODE_W-2:0], b};
							if (n_left != '0) begin
								n_left = n_left - 1'b1;
							end
							leaf_end = (n_left == '0);
						end
						default: begin
						end
					endcase
					// Leaf finished: emit and open the next one
					if (leaf_end) begin
						n_found          = n_found + 8'd1;
						res_v            = 1'b1;
						res.symbol       = n_sym;
						res.code_length  = n_len[hhu_pkg::CODE_LEN_W-1:0];
						res.code         = n_code;
						res.last_entry   = (n_found == n_total);
						if (n_found == n_total) begin
							n_done = 1'b1;
						end else begin
							n_phase = hhu_pkg::PH_SYMBOL;
							n_left  = ((n_found + 8'd1) == n_total) ?
								hhu_pkg::SYM_LAST_BITS : hhu_pkg::SYM_BITS;
							n_sym   = '0;
							n_len   = '0;
							n_code  = '0;
						end
					end
				end
			end
		end
	end

	// Parser state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hhu_pkg::PH_SYMBOL;
			left_q  <= '0;
			found_q <= '0;
			total_q <= '0;
			sym_q   <= '0;
			len_q   <= '0;
			code_q  <= '0;
			done_q  <= 1'b1;
		end else if (advance) begin
			phase_q <= n_phase;
			left_q  <= n_left;
			found_q <= n_found;
			total_q <= n_total;
			sym_q   <= n_sym;
			len_q   <= n_len;
			code_q  <= n_code;
			done_q  <= n_done;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			if (valid_s2 && leaf.ready) begin
				valid_s2 <= 1'b0;
			end
			if (advance && res_v) begin
				valid_s2 <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_v) begin
			leaf_s2 <= res;
		end
	end

	assign leaf.valid       = valid_s2;
	assign leaf.symbol      = leaf_s2.symbol;
	assign leaf.code_length = leaf_s2.code_length;
	assign leaf.code        = leaf_s2.code;
	assign leaf.last_entry  = leaf_s2.last_entry;

endmodule

`default_nettype wire

// ===== sv/hhu_checker.sv =====
// ----------------------------------------------------------------------------
// hhu_checker: port-level checks of the Huffman header unpacker
// Output hold under backpressure, input stall cause, zero-length leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module hhu_checker #(
	parameter int LENGTH_FIELD_BITS = 3
) (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              in_ready,
	input wire                              out_valid,
	input wire                              out_ready,
	input wire [hhu_pkg::SYMBOL_W-1:0]      out_symbol,
	input wire [hhu_pkg::CODE_LEN_W-1:0]    out_code_length,
	input wire [hhu_pkg::CODE_W-1:0]        out_code,
	input wire                              out_last_entry
);

	// A stalled result word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped under backpressure");

	// A stalled result word keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_symbol) && $stable(out_code_length)
			&& $stable(out_code) && $stable(out_last_entry))
		else $error("result payload changed under backpressure");

	// The input side stalls only behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled with the output free");

	// A leaf without code bits carries an empty code
	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (LENGTH_FIELD_BITS == 3) && (out_code_length == '0)
			|-> out_code == '0)
		else $error("zero-length leaf with code bits");

endmodule

bind huffman_header_unpacker hhu_checker #(
	.LENGTH_FIELD_BITS(LENGTH_FIELD_BITS)
) u_hhu_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_ready        (hdr.ready),
	.out_valid       (leaf.valid),
	.out_ready       (leaf.ready),
	.out_symbol      (leaf.symbol),
	.out_code_length (leaf.code_length),
	.out_code        (leaf.code),
	.out_last_entry  (leaf.last_entry)
);

`default_nettype wire
